// ----- design/source_text_tokenizer_macros.svh -----
// Assertion macros used by the verification file of the tokenizer, stt_checker.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- design/stt_pkg.sv -----
package stt_pkg;

    localparam int POS_BITS = 16;

    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_STRING = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_DROP   = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        KIND_EOF    = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_STRING = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_ERROR  = 4'd6,
        KIND_FUN    = 4'd7,
        KIND_LET    = 4'd8,
        KIND_NIL    = 4'd9,
        KIND_OR     = 4'd10
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] offset;
        logic [15:0] length;
    } tok_t;

    // One queue entry holds every token that a single byte produced.
    typedef struct packed {
        logic pair;
        tok_t first;
        tok_t second;
    } entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [23:0] KW_FUN = 24'h66756E;
    localparam logic [23:0] KW_LET = 24'h6C6574;
    localparam logic [23:0] KW_NIL = 24'h6E696C;
    localparam logic [23:0] KW_OR  = 24'h006F72;

    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? v : v + pos_t'(1);
    endfunction

    function automatic logic [15:0] clamp16(input pos_t v);
        logic [32:0] wide;
        wide = 33'(v);
        return (wide > 33'h0FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic tok_t make_tok(input tok_kind_t kind, input pos_t off, input pos_t len);
        tok_t t;
        t.kind   = kind;
        t.offset = clamp16(off);
        t.length = clamp16(len);
        return t;
    endfunction

endpackage

// ----- design/stt_front.sv -----
module stt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    output logic             in_ready,
    input  logic             queue_full,
    output logic             push,
    output stt_pkg::entry_t  push_entry
);

    stt_pkg::mode_t mode_reg, mode_next;
    stt_pkg::pos_t  pos_reg, pos_next;
    stt_pkg::pos_t  start_reg, start_next;
    logic           digits_reg, digits_next;
    logic [23:0]    prefix_reg, prefix_next;

    logic                accept;
    logic                alnum;
    logic                has_word;
    logic                has_start;
    logic                start_tok;
    stt_pkg::pos_t       word_len;
    stt_pkg::tok_kind_t  word_kind;
    stt_pkg::tok_t       word_tok;
    stt_pkg::tok_t       start_tok_val;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign alnum    = stt_pkg::is_letter(in_byte) || stt_pkg::is_digit(in_byte);
    assign word_len = pos_reg - start_reg;

    always_comb
    begin
        word_kind = stt_pkg::KIND_IDENT;
        if (digits_reg)
        begin
            word_kind = stt_pkg::KIND_NUMBER;
        end
        else if (pos_reg != stt_pkg::POS_MAX)
        begin
            if (word_len == stt_pkg::pos_t'(3))
            begin
                if (prefix_reg == stt_pkg::KW_FUN)
                begin
                    word_kind = stt_pkg::KIND_FUN;
                end
                else if (prefix_reg == stt_pkg::KW_LET)
                begin
                    word_kind = stt_pkg::KIND_LET;
                end
                else if (prefix_reg == stt_pkg::KW_NIL)
                begin
                    word_kind = stt_pkg::KIND_NIL;
                end
            end
            else if (word_len == stt_pkg::pos_t'(2) && prefix_reg == stt_pkg::KW_OR)
            begin
                word_kind = stt_pkg::KIND_OR;
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        digits_next   = digits_reg;
        prefix_next   = prefix_reg;
        has_word      = 1'b0;
        has_start     = 1'b0;
        start_tok     = 1'b0;
        word_tok      = stt_pkg::make_tok(word_kind, start_reg, word_len);
        start_tok_val = stt_pkg::make_tok(stt_pkg::KIND_EOF, pos_reg, '0);

        unique case (mode_reg)
            stt_pkg::MODE_WORD:
            begin
                if (alnum)
                begin
                    if (!stt_pkg::is_digit(in_byte))
                    begin
                        digits_next = 1'b0;
                    end
                    if (word_len < stt_pkg::pos_t'(3))
                    begin
                        prefix_next = {prefix_reg[15:0], in_byte};
                    end
                    pos_next = stt_pkg::sat_inc(pos_reg);
                end
                else
                begin
                    has_word  = 1'b1;
                    start_tok = 1'b1;
                end
            end
            stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE:
            begin
                if (in_byte == stt_pkg::CH_NUL)
                begin
                    has_word    = 1'b1;
                    word_tok    = stt_pkg::make_tok(stt_pkg::KIND_ERROR, start_reg, word_len);
                    mode_next   = stt_pkg::MODE_IDLE;
                    pos_next    = '0;
                    start_next  = '0;
                    digits_next = 1'b1;
                    prefix_next = '0;
                end
                else if (mode_reg == stt_pkg::MODE_ESCAPE)
                begin
                    mode_next = stt_pkg::MODE_STRING;
                    pos_next  = stt_pkg::sat_inc(pos_reg);
                end
                else if (in_byte == stt_pkg::CH_BSLASH)
                begin
                    mode_next = stt_pkg::MODE_ESCAPE;
                    pos_next  = stt_pkg::sat_inc(pos_reg);
                end
                else if (in_byte == stt_pkg::CH_QUOTE)
                begin
                    has_word  = 1'b1;
                    word_tok  = stt_pkg::make_tok(stt_pkg::KIND_STRING, start_reg,
                                                  stt_pkg::sat_inc(pos_reg) - start_reg);
                    mode_next = stt_pkg::MODE_IDLE;
                    pos_next  = stt_pkg::sat_inc(pos_reg);
                end
                else
                begin
                    pos_next = stt_pkg::sat_inc(pos_reg);
                end
            end
            stt_pkg::MODE_DROP:
            begin
                if (in_byte == stt_pkg::CH_NUL)
                begin
                    mode_next   = stt_pkg::MODE_IDLE;
                    pos_next    = '0;
                    start_next  = '0;
                    digits_next = 1'b1;
                    prefix_next = '0;
                end
                else
                begin
                    pos_next = stt_pkg::sat_inc(pos_reg);
                end
            end
            default:
            begin
                start_tok = 1'b1;
            end
        endcase

        if (start_tok)
        begin
            pos_next = stt_pkg::sat_inc(pos_reg);
            if (in_byte == stt_pkg::CH_NUL)
            begin
                has_start   = 1'b1;
                mode_next   = stt_pkg::MODE_IDLE;
                pos_next    = '0;
                start_next  = '0;
                digits_next = 1'b1;
                prefix_next = '0;
            end
            else if (in_byte == stt_pkg::CH_SPACE || in_byte == stt_pkg::CH_TAB ||
                     in_byte == stt_pkg::CH_NL)
            begin
                mode_next = stt_pkg::MODE_IDLE;
            end
            else if (alnum)
            begin
                mode_next   = stt_pkg::MODE_WORD;
                start_next  = pos_reg;
                digits_next = stt_pkg::is_digit(in_byte);
                prefix_next = {16'h0000, in_byte};
            end
            else if (in_byte == stt_pkg::CH_QUOTE)
            begin
                mode_next  = stt_pkg::MODE_STRING;
                start_next = pos_reg;
            end
            else if (in_byte == stt_pkg::CH_LPAREN || in_byte == stt_pkg::CH_RPAREN)
            begin
                has_start     = 1'b1;
                mode_next     = stt_pkg::MODE_IDLE;
                start_tok_val = stt_pkg::make_tok(
                    (in_byte == stt_pkg::CH_LPAREN) ? stt_pkg::KIND_LPAREN : stt_pkg::KIND_RPAREN,
                    pos_reg, stt_pkg::sat_inc(pos_reg) - pos_reg);
            end
            else
            begin
                has_start     = 1'b1;
                mode_next     = stt_pkg::MODE_DROP;
                start_tok_val = stt_pkg::make_tok(stt_pkg::KIND_ERROR, pos_reg, '0);
            end
        end
    end

    always_comb
    begin
        push_entry.pair   = has_word && has_start;
        push_entry.first  = has_word ? word_tok : start_tok_val;
        push_entry.second = start_tok_val;
        push              = accept && (has_word || has_start);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            digits_reg <= 1'b1;
            prefix_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            digits_reg <= digits_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ----- design/stt_queue.sv -----
module stt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stt_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output stt_pkg::entry_t  head
);

    typedef logic [stt_pkg::QUEUE_PTR_BITS-1:0] ptr_t;
    typedef logic [stt_pkg::QUEUE_PTR_BITS:0]   count_t;

    stt_pkg::entry_t mem_reg [stt_pkg::QUEUE_DEPTH];

    ptr_t   wr_ptr_reg, wr_ptr_next;
    ptr_t   rd_ptr_reg, rd_ptr_next;
    count_t count_reg, count_next;

    assign full      = (count_reg == count_t'(stt_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + ptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + ptr_t'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/stt_back.sv -----
module stt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  stt_pkg::entry_t  head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output stt_pkg::tok_t    out_tok,
    output logic             out_last
);

    stt_pkg::entry_t cur_reg, cur_next;
    logic            valid_reg, valid_next;
    logic            sel_reg, sel_next;
    logic            take;
    logic            load;

    assign out_valid = valid_reg;
    assign out_tok   = sel_reg ? cur_reg.second : cur_reg.first;
    assign out_last  = sel_reg || !cur_reg.pair;
    assign take      = valid_reg && out_ready;
    assign load      = !valid_reg || (take && out_last);
    assign pop       = load && not_empty;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            cur_next   = head;
            valid_next = not_empty;
            sel_next   = 1'b0;
        end
        else if (take)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ----- design/source_text_tokenizer.sv -----
// Source text tokenizer. Text enters one byte per transaction on the slave
// stream, and a zero byte ends the text; input runs at one byte per clock
// while the output keeps up. Each byte produces zero, one or two tokens,
// which leave on the master stream one per transaction with tlast set on the
// last token of that byte. The output port moves one token per cycle while
// m_tready is high, so a byte that closes a word and also yields a token of
// its own takes two output transfers; a four-entry queue between the scanner
// and the output register absorbs this and any output stall. A token passes
// through the queue memory and then the output register on its way out.
module source_text_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [3:0] token_type, [19:4] token_offset,
                                  // [35:20] token_length, [39:36] zero
    output logic        m_tlast   // last_of_run
);

    logic            queue_full;
    logic            push;
    stt_pkg::entry_t push_entry;
    logic            pop;
    logic            not_empty;
    stt_pkg::entry_t head;
    stt_pkg::tok_t   out_tok;

    stt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tok    (out_tok),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, out_tok.length, out_tok.offset, out_tok.kind};

endmodule

// ----- design/stt_checker.sv -----
`include "source_text_tokenizer_macros.svh"

module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    logic [3:0]  kind;
    logic [15:0] length;
    logic        out_stall;
    logic        eof_tok;
    logic        paren_tok;
    logic        keyword_tok;

    assign kind        = m_tdata[3:0];
    assign length      = m_tdata[35:20];
    assign out_stall   = m_tvalid && !m_tready;
    assign eof_tok     = m_tvalid && kind == stt_pkg::KIND_EOF;
    assign paren_tok   = m_tvalid && (kind == stt_pkg::KIND_LPAREN ||
                                      kind == stt_pkg::KIND_RPAREN);
    assign keyword_tok = m_tvalid && (kind == stt_pkg::KIND_FUN || kind == stt_pkg::KIND_LET ||
                                      kind == stt_pkg::KIND_NIL);

    `STT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable({m_tlast, m_tdata}))
    `STT_ASSERT_SAME(a_eof_shape, clk, rst_n, eof_tok, length == 16'h0000 && m_tlast)
    `STT_ASSERT_SAME(a_paren_shape, clk, rst_n, paren_tok, length[15:1] == 15'h0000 && m_tlast)
    `STT_ASSERT_SAME(a_keyword_len, clk, rst_n, keyword_tok, length == 16'd3)
    `STT_ASSERT_SAME(a_full_has_out, clk, rst_n, !s_tready, m_tvalid)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    class token_scoreboard;

        typedef struct {
            stt_pkg::tok_kind_t kind;
            logic [15:0]        offset;
            logic [15:0]        length;
            logic               last;
        } want_t;

        stt_pkg::mode_t mode;
        stt_pkg::pos_t  pos;
        stt_pkg::pos_t  start;
        logic           digits;
        logic [23:0]    prefix;
        want_t          want[$];
        int             errors;
        int             sent_bytes;

        function new();
            errors = 0;
            sent_bytes = 0;
            restart();
        endfunction

        function void restart();
            mode = stt_pkg::MODE_IDLE;
            pos = '0;
            start = '0;
            digits = 1'b1;
            prefix = '0;
        endfunction

        function stt_pkg::pos_t bump(stt_pkg::pos_t v);
            return (v == '1) ? v : v + stt_pkg::pos_t'(1);
        endfunction

        function logic [15:0] fit16(stt_pkg::pos_t v);
            logic [32:0] w;
            w = 33'(v);
            return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
        endfunction

        function logic digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function logic alnum(logic [7:0] b);
            return digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function void emit(stt_pkg::tok_kind_t kind, stt_pkg::pos_t off, stt_pkg::pos_t len);
            want_t t;
            t.kind = kind;
            t.offset = fit16(off);
            t.length = fit16(len);
            t.last = 1'b0;
            want.push_back(t);
        endfunction

        function stt_pkg::tok_kind_t word_kind();
            stt_pkg::pos_t span;
            span = pos - start;
            if (digits)
                return stt_pkg::KIND_NUMBER;
            if (pos != '1)
            begin
                if (span == 3)
                begin
                    if (prefix == stt_pkg::KW_FUN)
                        return stt_pkg::KIND_FUN;
                    if (prefix == stt_pkg::KW_LET)
                        return stt_pkg::KIND_LET;
                    if (prefix == stt_pkg::KW_NIL)
                        return stt_pkg::KIND_NIL;
                end
                else if (span == 2 && prefix == stt_pkg::KW_OR)
                    return stt_pkg::KIND_OR;
            end
            return stt_pkg::KIND_IDENT;
        endfunction

        function void open_token(logic [7:0] b);
            stt_pkg::pos_t p;
            p = pos;
            if (b == stt_pkg::CH_NUL)
            begin
                emit(stt_pkg::KIND_EOF, p, '0);
                restart();
                return;
            end
            if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_TAB || b == stt_pkg::CH_NL)
            begin
                mode = stt_pkg::MODE_IDLE;
            end
            else if (alnum(b))
            begin
                mode = stt_pkg::MODE_WORD;
                start = p;
                digits = digit(b);
                prefix = {16'h0000, b};
            end
            else if (b == stt_pkg::CH_QUOTE)
            begin
                mode = stt_pkg::MODE_STRING;
                start = p;
            end
            else if (b == stt_pkg::CH_LPAREN || b == stt_pkg::CH_RPAREN)
            begin
                emit((b == stt_pkg::CH_LPAREN) ? stt_pkg::KIND_LPAREN : stt_pkg::KIND_RPAREN,
                     p, bump(p) - p);
                mode = stt_pkg::MODE_IDLE;
            end
            else
            begin
                emit(stt_pkg::KIND_ERROR, p, '0);
                mode = stt_pkg::MODE_DROP;
            end
            pos = bump(p);
        endfunction

        function void note_byte(logic [7:0] b);
            int            n0;
            stt_pkg::pos_t span;
            stt_pkg::pos_t fin;
            n0 = want.size();
            span = pos - start;
            sent_bytes++;
            case (mode)
                stt_pkg::MODE_WORD:
                    if (alnum(b))
                    begin
                        if (!digit(b))
                            digits = 1'b0;
                        if (span < 3)
                            prefix = {prefix[15:0], b};
                        pos = bump(pos);
                    end
                    else
                    begin
                        emit(word_kind(), start, span);
                        open_token(b);
                    end
                stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE:
                    if (b == stt_pkg::CH_NUL)
                    begin
                        emit(stt_pkg::KIND_ERROR, start, span);
                        restart();
                    end
                    else if (mode == stt_pkg::MODE_ESCAPE)
                    begin
                        mode = stt_pkg::MODE_STRING;
                        pos = bump(pos);
                    end
                    else if (b == stt_pkg::CH_BSLASH)
                    begin
                        mode = stt_pkg::MODE_ESCAPE;
                        pos = bump(pos);
                    end
                    else if (b == stt_pkg::CH_QUOTE)
                    begin
                        fin = bump(pos);
                        emit(stt_pkg::KIND_STRING, start, fin - start);
                        mode = stt_pkg::MODE_IDLE;
                        pos = fin;
                    end
                    else
                    begin
                        pos = bump(pos);
                    end
                stt_pkg::MODE_DROP:
                    if (b == stt_pkg::CH_NUL)
                        restart();
                    else
                        pos = bump(pos);
                default:
                    open_token(b);
            endcase
            if (want.size() > n0)
                want[want.size() - 1].last = 1'b1;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_token(logic [39:0] d, logic l);
            want_t e;
            if (want.size() == 0)
            begin
                flag($sformatf("ERROR: unexpected token data %h last %b", d, l));
                return;
            end
            e = want.pop_front();
            if (d[3:0] != e.kind || d[19:4] != e.offset || d[35:20] != e.length
                || l != e.last)
                flag($sformatf({"ERROR: expected kind %0d offset %0d length %0d last %0d,",
                                " got kind %0d offset %0d length %0d last %0d"},
                               e.kind, e.offset, e.length, e.last,
                               d[3:0], d[19:4], d[35:20], l));
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    token_scoreboard sb = new();
    bit              calm = 1'b0;

    always #5 clk = ~clk;

    source_text_tokenizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    task automatic send_byte(input logic [7:0] b);
        bit hs;
        if (!calm && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 34);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
        begin
            @(negedge clk);
            hs = s_tready;
            @(posedge clk);
        end while (!hs);
        sb.note_byte(b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] alnum_byte(input bit want_digit);
        if (want_digit)
            return 8'("0" + $urandom_range(9));
        return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(2))
            0:       return stt_pkg::CH_SPACE;
            1:       return stt_pkg::CH_TAB;
            default: return stt_pkg::CH_NL;
        endcase
    endfunction

    function automatic string keyword_like();
        case ($urandom_range(9))
            0:       return "fun";
            1:       return "let";
            2:       return "nil";
            3:       return "or";
            4:       return "fu";
            5:       return "funk";
            6:       return "lets";
            7:       return "ni";
            8:       return "orb";
            default: return "Let";
        endcase
    endfunction

    // An open string may end in a backslash, so the zero byte that follows
    // lands on the escape state.
    task automatic send_string(input bit closed);
        logic [7:0] b;
        repeat ($urandom_range(0, 6))
        begin
            b = any_byte();
            if (b == stt_pkg::CH_QUOTE || b == stt_pkg::CH_BSLASH)
            begin
                send_byte(stt_pkg::CH_BSLASH);
                send_byte(any_byte());
            end
            else
            begin
                send_byte(b);
            end
        end
        if (closed)
            send_byte(stt_pkg::CH_QUOTE);
        else if ($urandom_range(1))
            send_byte(stt_pkg::CH_BSLASH);
    endtask

    task automatic random_text();
        int k;
        bit dig;
        repeat ($urandom_range(1, 10))
        begin
            k = $urandom_range(99);
            dig = ($urandom_range(3) == 0);
            if (k < 20)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(alnum_byte(dig));
            end
            else if (k < 32)
            begin
                send_text(keyword_like());
            end
            else if (k < 44)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(alnum_byte(1'b1));
            end
            else if (k < 58)
            begin
                send_byte(stt_pkg::CH_QUOTE);
                send_string(1'b1);
            end
            else if (k < 70)
            begin
                send_byte($urandom_range(1) ? stt_pkg::CH_LPAREN : stt_pkg::CH_RPAREN);
            end
            else if (k < 78)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(any_byte());
            end
            if ($urandom_range(99) < 55)
                send_byte(blank_byte());
        end
        if ($urandom_range(9) == 0)
        begin
            send_byte(stt_pkg::CH_QUOTE);
            send_string(1'b0);
        end
        send_byte(stt_pkg::CH_NUL);
    endtask

    initial
    begin
        bit          fire;
        logic [39:0] d;
        logic        l;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            fire = rst_n && m_tvalid && m_tready;
            d = m_tdata;
            l = m_tlast;
            @(posedge clk);
            if (fire)
                sb.check_token(d, l);
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    initial
    begin
        int base;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("fun(let)nil or 7\"\\\"\"");
        send_byte(stt_pkg::CH_NUL);
        send_text("x");
        send_byte(stt_pkg::CH_NUL);
        send_text("\"\\");
        send_byte(stt_pkg::CH_NUL);
        send_byte(8'hFF);
        send_text("A?");
        send_byte(stt_pkg::CH_NUL);
        send_byte(stt_pkg::CH_QUOTE);
        send_byte(stt_pkg::CH_NUL);

        // Hold off until the output side has caught up completely.
        s_tvalid <= 1'b0;
        while (sb.want.size() != 0)
            @(posedge clk);

        base = sb.sent_bytes;
        while (sb.sent_bytes - base < 1450)
        begin
            calm = (sb.sent_bytes - base >= 600) && (sb.sent_bytes - base < 900);
            random_text();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.want.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.want.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
